// ===== rtl/pal_pkg.sv =====
// ============================================================================
// pal_pkg
// Shared types, codes and constants of the push/ack link tracker.
// ============================================================================
package pal_pkg;

    localparam int NUM_CLIENTS_DEF = 64;

    localparam int MODE_W    = 3;
    localparam int SLOT_W    = 6;
    localparam int VER_W     = 16;
    localparam int SEQ_W     = 32;
    localparam int TIME_W    = 48;
    localparam int VERDICT_W = 3;
    localparam int TMO_W     = 32;
    localparam int REQ_W     = 15;

    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 40;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [MODE_W-1:0] MODE_VERSION = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READY   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REJECT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RETRY   = 3'd5;

    localparam logic [VERDICT_W-1:0] VERDICT_READY      = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_UNREPORTED = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_VER_ZERO   = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_TOO_OLD    = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_NO_PUSH    = 3'd4;
    localparam logic [VERDICT_W-1:0] VERDICT_AWAITING   = 3'd5;
    localparam logic [VERDICT_W-1:0] VERDICT_REJECTED   = 3'd6;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_REQ_VER = 1'b1;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 32'd5000;
    localparam logic [REQ_W-1:0] REQ_VER_RESET = 15'd1;

    typedef struct packed {
        logic signed [VER_W-1:0] version;
        logic [SEQ_W-1:0]        pending;
        logic [SEQ_W-1:0]        ready;
        logic [TIME_W-1:0]       push_time;
        logic                    retry_used;
        logic                    reject_seen;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        version:     16'hFFFF,
        pending:     32'd0,
        ready:       32'd0,
        push_time:   48'd0,
        retry_used:  1'b0,
        reject_seen: 1'b0
    };

    typedef struct packed {
        logic [TMO_W-1:0] timeout_ms;
        logic [REQ_W-1:0] required_version;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } cmd_t;

endpackage

// ===== rtl/pal_cfg.sv =====
// ============================================================================
// pal_cfg
// APB register file holding the timeout and the required client version.
// ============================================================================
module pal_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pal_pkg::APB_AW-1:0]   paddr,
    input  logic [pal_pkg::APB_DW-1:0]   pwdata,
    output logic [pal_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output pal_pkg::cfg_t                cfg
);
    import pal_pkg::*;

    logic [TMO_W-1:0] timeout_reg;
    logic [REQ_W-1:0] req_ver_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            req_ver_reg <= REQ_VER_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_TIMEOUT)
                timeout_reg <= pwdata[TMO_W-1:0];
            else
                req_ver_reg <= pwdata[REQ_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_TIMEOUT)
            prdata = timeout_reg;
        else
            prdata = {{(APB_DW-REQ_W){1'b0}}, req_ver_reg};
    end

    assign cfg.timeout_ms       = timeout_reg;
    assign cfg.required_version = req_ver_reg;

endmodule

// ===== rtl/pal_ctrl.sv =====
// ============================================================================
// pal_ctrl
// Controller: sequences capture/read and execute/write-back of each request
// and owns the result valid flag.
// ============================================================================
module pal_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output pal_pkg::cmd_t cmd
);
    import pal_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    assign s_tready    = (state_reg == ST_IDLE);
    assign cmd.capture = s_tvalid && s_tready;
    assign cmd.exec    = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);
    assign m_tvalid    = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (cmd.exec)
                    state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.exec || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/pal_dpath.sv =====
// ============================================================================
// pal_dpath
// Datapath: slot table memory with valid bits, sequence counter, event
// update logic, verdict and the result register.
// ============================================================================
module pal_dpath #(
    parameter int NUM_CLIENTS = pal_pkg::NUM_CLIENTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pal_pkg::cmd_t                  cmd,
    input  pal_pkg::cfg_t                  cfg,
    input  logic [pal_pkg::MODE_W-1:0]     in_mode,
    input  logic [pal_pkg::S_DATA_W-1:0]   in_data,
    output logic [pal_pkg::M_DATA_W-1:0]   out_data
);
    import pal_pkg::*;

    localparam int DEPTH = (NUM_CLIENTS < (1 << SLOT_W)) ? NUM_CLIENTS : (1 << SLOT_W);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    entry_t               mem [DEPTH];
    logic [DEPTH-1:0]     vld_reg;

    entry_t               rd_entry_reg;
    logic                 rd_valid_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 in_range_reg;
    logic signed [VER_W-1:0] ver_reg;
    logic [SEQ_W-1:0]     ack_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [SEQ_W-1:0]     seq_reg;
    logic [SEQ_W-1:0]     seq_next;

    logic [SLOT_W-1:0]    in_slot;
    logic [IDX_W-1:0]     in_idx;
    logic                 in_range;

    entry_t               cur;
    entry_t               nxt;
    logic [SEQ_W-1:0]     issued;
    logic                 repush;
    logic [TIME_W-1:0]    elapsed;
    logic [VERDICT_W-1:0] verdict;

    logic [SEQ_W-1:0]     issued_reg;
    logic                 repush_reg;
    logic [VERDICT_W-1:0] verdict_reg;

    assign in_slot  = in_data[SLOT_W-1:0];
    assign in_idx   = IDX_W'(in_slot);
    assign in_range = (32'(in_slot) < 32'(NUM_CLIENTS));

    always_ff @(posedge clk)
    begin
        if (cmd.exec && in_range_reg)
            mem[idx_reg] <= nxt;
        if (cmd.capture)
        begin
            rd_entry_reg <= mem[in_idx];
            rd_valid_reg <= vld_reg[in_idx];
            mode_reg     <= in_mode;
            idx_reg      <= in_idx;
            in_range_reg <= in_range;
            ver_reg      <= in_data[SLOT_W+VER_W-1:SLOT_W];
            ack_reg      <= in_data[SLOT_W+VER_W+SEQ_W-1:SLOT_W+VER_W];
            now_reg      <= in_data[SLOT_W+VER_W+SEQ_W+TIME_W-1:SLOT_W+VER_W+SEQ_W];
        end
        if (cmd.exec)
        begin
            issued_reg  <= issued;
            repush_reg  <= repush;
            verdict_reg <= verdict;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            seq_reg <= '0;
        end
        else if (cmd.exec && in_range_reg)
        begin
            vld_reg[idx_reg] <= 1'b1;
            seq_reg          <= (mode_reg == MODE_PUSH) ? seq_next : seq_reg;
        end
    end

    assign cur      = rd_valid_reg ? rd_entry_reg : ENTRY_RESET;
    assign seq_next = (seq_reg == {SEQ_W{1'b1}}) ? SEQ_W'(1) : seq_reg + SEQ_W'(1);
    assign elapsed  = now_reg - cur.push_time;

    always_comb
    begin
        nxt    = cur;
        issued = '0;
        repush = 1'b0;
        unique case (mode_reg)
            MODE_VERSION:
                nxt.version = ver_reg;
            MODE_PUSH:
            begin
                nxt.pending     = seq_next;
                nxt.push_time   = now_reg;
                nxt.retry_used  = 1'b0;
                nxt.reject_seen = 1'b0;
                issued          = seq_next;
            end
            MODE_READY:
            begin
                if (ack_reg != '0)
                begin
                    nxt.ready = ack_reg;
                    if (ack_reg == cur.pending)
                        nxt.reject_seen = 1'b0;
                end
            end
            MODE_REJECT:
                nxt.reject_seen = 1'b1;
            MODE_RETRY:
            begin
                if (cur.pending != '0 && !cur.retry_used && cur.ready != cur.pending)
                begin
                    if (cur.reject_seen ||
                        elapsed >= {{(TIME_W-TMO_W){1'b0}}, cfg.timeout_ms})
                    begin
                        nxt.retry_used = 1'b1;
                        repush         = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (!in_range_reg)
        begin
            issued = '0;
            repush = 1'b0;
        end
    end

    always_comb
    begin
        priority if (!in_range_reg || nxt.version < 0)
            verdict = VERDICT_UNREPORTED;
        else if (nxt.version == 0)
            verdict = VERDICT_VER_ZERO;
        else if (nxt.version < $signed({1'b0, cfg.required_version}))
            verdict = VERDICT_TOO_OLD;
        else if (nxt.pending == '0)
            verdict = VERDICT_NO_PUSH;
        else if (nxt.ready == nxt.pending)
            verdict = VERDICT_READY;
        else if (nxt.reject_seen)
            verdict = VERDICT_REJECTED;
        else
            verdict = VERDICT_AWAITING;
    end

    assign out_data = {{(M_DATA_W-SEQ_W-1-VERDICT_W){1'b0}}, verdict_reg, repush_reg,
                       issued_reg};

endmodule

// ===== rtl/push_ack_link_tracker.sv =====
// ============================================================================
// push_ack_link_tracker
// Per-client link tracker for pushes, ready/reject acknowledgements and
// single retries, with a global wrapping sequence counter.
// ============================================================================
// Each request on the s_ channel is one link event for one client slot; the
// mode travels in s_tuser. Every request yields exactly one result on the m_
// channel with the issued sequence, the retry decision and the slot verdict.
// A request is captured and its table entry read at the accepting edge, and
// it is executed and written back once the output register is free, which
// loads its result there. No new request is taken until the current one has
// executed, since the slot table memory is a single-port read-modify-write.
// The result sits in an output register, so the next request is accepted
// while a result waits; if the receiver stalls, the second request holds in
// execute until the output register frees, and s_tready stays low meanwhile.
// Reset empties the table through per-slot valid bits (unwritten slots read
// as never reported and nothing pushed), clears the sequence counter and
// loads the timeout with 5000 ms and the required version with 1. The user
// writes the registers over APB only while no request is in flight; the
// block itself does not enforce this.
// ============================================================================
module push_ack_link_tracker #(
    parameter int NUM_CLIENTS = pal_pkg::NUM_CLIENTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: client_slot[5:0], reported_version[21:6], ack_seq[53:22],
    // now_ms[101:54], zero fill[103:102].
    input  logic [pal_pkg::S_DATA_W-1:0]  s_tdata,
    // tuser: mode[2:0].
    input  logic [pal_pkg::MODE_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: issued_seq[31:0], repush[32], verdict[35:33], zero fill[39:36].
    output logic [pal_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pal_pkg::APB_AW-1:0]    paddr,
    input  logic [pal_pkg::APB_DW-1:0]    pwdata,
    output logic [pal_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import pal_pkg::*;

    cfg_t cfg;
    cmd_t cmd;

    pal_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    pal_dpath #(
        .NUM_CLIENTS (NUM_CLIENTS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .in_mode  (s_tuser),
        .in_data  (s_tdata),
        .out_data (m_tdata)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while the previous one is still executing");

    a_exec_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> m_tvalid)
        else $error("executed request did not present a result");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[35:33] != 3'd7))
        else $error("result verdict outside the defined codes");

    a_push_no_repush: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[32] && (m_tdata[31:0] != 32'd0)))
        else $error("result both issued a sequence and granted a retry");

endmodule
